// File: rtl/dar_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dar_pkg: shared types and constants for the duplicate address registry
// Request, table entry and reply layouts, status codes and the command and
// status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package dar_pkg;

    localparam int TABLE_DEPTH_DEF = 16;
    localparam int NUM_IFACES      = 4;

    localparam int IFACE_W = 2;
    localparam int ADDR_W  = 64;
    localparam int EUI_W   = 64;
    localparam int LIFE_W  = 16;
    localparam int STAT_W  = 2;
    localparam int CFG_W   = 4;

    localparam int IN_TDATA_W  = 344;
    localparam int OUT_TDATA_W = 344;

    localparam logic [STAT_W-1:0] ST_SUCCESS    = 2'd0;
    localparam logic [STAT_W-1:0] ST_DUPLICATE  = 2'd1;
    localparam logic [STAT_W-1:0] ST_TABLE_FULL = 2'd2;

    typedef struct packed {
        logic [IFACE_W-1:0] iface;
        logic [ADDR_W-1:0]  src_hi;
        logic [ADDR_W-1:0]  src_lo;
        logic [ADDR_W-1:0]  reg_hi;
        logic [ADDR_W-1:0]  reg_lo;
        logic [EUI_W-1:0]   eui;
        logic [LIFE_W-1:0]  life;
    } t_req;

    typedef struct packed {
        logic [IFACE_W-1:0] iface;
        logic [ADDR_W-1:0]  addr_hi;
        logic [ADDR_W-1:0]  addr_lo;
        logic [EUI_W-1:0]   owner;
        logic [LIFE_W-1:0]  lifetime;
    } t_entry;

    typedef struct packed {
        logic [IFACE_W-1:0] iface;
        logic [STAT_W-1:0]  status;
        logic [LIFE_W-1:0]  life;
        logic [EUI_W-1:0]   eui;
        logic [ADDR_W-1:0]  reg_hi;
        logic [ADDR_W-1:0]  reg_lo;
        logic [ADDR_W-1:0]  dst_hi;
        logic [ADDR_W-1:0]  dst_lo;
    } t_rsp;

    typedef struct packed {
        logic              load_req;
        logic              step;
        logic              commit;
        logic              wr_en;
        logic              wr_hit;
        logic              inc_fill;
        logic [STAT_W-1:0] status;
    } t_cmd;

    typedef struct packed {
        logic drop;
        logic more;
        logic rd_pend;
        logic hit;
        logic own_eq;
        logic full;
        logic out_busy;
    } t_sts;

endpackage

// File: rtl/duplicate_address_registry.sv
`timescale 1ns / 1ps
// Timing: a dropped request returns from FILTER to IDLE with no reply; otherwise
// it passes FILTER, SCAN and RESOLVE and the reply is registered in the output
// register, RESOLVE waiting while that register still holds an unaccepted word
// (scan stops early on a hit). A new request is taken only in IDLE, after the
// last one is resolved; the scan of the entry memory, one entry a cycle, sets the rate.
// Reset: synchronous, active low; empties the table and disables all ifaces.
// ----------------------------------------------------------------------------
// duplicate_address_registry: border router duplicate address detection
// Filters registration requests, looks up the shared registry and answers
// success, duplicate or table full while inserting or refreshing entries.
// ----------------------------------------------------------------------------
module duplicate_address_registry #(
    parameter int TABLE_DEPTH = dar_pkg::TABLE_DEPTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // iface, src_addr_hi, src_addr_lo, reg_addr_hi, reg_addr_lo, owner_eui,
    // reg_lifetime, zero pad
    input  logic [dar_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // out_iface, status, out_lifetime, out_eui, out_reg_hi, out_reg_lo,
    // dst_addr_hi, dst_addr_lo, zero pad
    output logic [dar_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [dar_pkg::CFG_W-1:0]        i_cfg_data
);
    import dar_pkg::*;

    t_req w_req;
    t_rsp w_rsp;
    t_cmd w_cmd;
    t_sts w_sts;

    assign w_req.iface  = s_axis_tdata[1:0];
    assign w_req.src_hi = s_axis_tdata[65:2];
    assign w_req.src_lo = s_axis_tdata[129:66];
    assign w_req.reg_hi = s_axis_tdata[193:130];
    assign w_req.reg_lo = s_axis_tdata[257:194];
    assign w_req.eui    = s_axis_tdata[321:258];
    assign w_req.life   = s_axis_tdata[337:322];

    assign o_cfg_ready = 1'b1;

    dar_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .o_s_ready (s_axis_tready),
        .i_sts     (w_sts),
        .o_cmd     (w_cmd)
    );

    dar_dpath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_req       (w_req),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out       (w_rsp)
    );

    assign m_axis_tdata = {4'b0, w_rsp.dst_lo, w_rsp.dst_hi, w_rsp.reg_lo, w_rsp.reg_hi,
                           w_rsp.eui, w_rsp.life, w_rsp.status, w_rsp.iface};

endmodule

// File: rtl/dar_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dar_ctrl: request sequencer
// Accepts a request, filters it, walks the table scan and resolves the
// outcome into a table write and a reply word.
// ----------------------------------------------------------------------------
module dar_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_valid,
    output logic          o_s_ready,
    input  dar_pkg::t_sts i_sts,
    output dar_pkg::t_cmd o_cmd
);
    import dar_pkg::*;

    localparam logic [1:0] S_IDLE    = 2'd0;
    localparam logic [1:0] S_FILTER  = 2'd1;
    localparam logic [1:0] S_SCAN    = 2'd2;
    localparam logic [1:0] S_RESOLVE = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    assign o_s_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.load_req = i_s_valid && o_s_ready;
        case (r_state)
            S_IDLE: begin
                if (o_cmd.load_req) begin
                    n_state = S_FILTER;
                end
            end
            S_FILTER: begin
                n_state = i_sts.drop ? S_IDLE : S_SCAN;
            end
            S_SCAN: begin
                if (i_sts.hit) begin
                    n_state = S_RESOLVE;
                end else if (i_sts.more) begin
                    o_cmd.step = 1'b1;
                end else if (!i_sts.rd_pend) begin
                    n_state = S_RESOLVE;
                end
            end
            S_RESOLVE: begin
                // hold until the reply register can take a new word
                if (!i_sts.out_busy) begin
                    o_cmd.commit = 1'b1;
                    if (i_sts.hit) begin
                        if (i_sts.own_eq) begin
                            o_cmd.wr_en  = 1'b1;
                            o_cmd.wr_hit = 1'b1;
                            o_cmd.status = ST_SUCCESS;
                        end else begin
                            o_cmd.status = ST_DUPLICATE;
                        end
                    end else if (!i_sts.full) begin
                        o_cmd.wr_en    = 1'b1;
                        o_cmd.inc_fill = 1'b1;
                        o_cmd.status   = ST_SUCCESS;
                    end else begin
                        o_cmd.status = ST_TABLE_FULL;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_step_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.step |-> (r_state == S_SCAN) && i_sts.more && !i_sts.hit)
        else $error("table read issued outside the scan or past the fill level");

    a_commit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |-> !i_sts.out_busy)
        else $error("reply committed while the output word is still held");

    a_drop_no_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FILTER) && i_sts.drop |=> (r_state == S_IDLE))
        else $error("dropped request entered the scan");

endmodule

// File: rtl/dar_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dar_dpath: registry datapath
// Request register, interface enable register, entry memory with registered
// read, scan compare, fill counter and the reply output register.
// ----------------------------------------------------------------------------
module dar_dpath #(
    parameter int TABLE_DEPTH = dar_pkg::TABLE_DEPTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  dar_pkg::t_cmd              i_cmd,
    output dar_pkg::t_sts              o_sts,
    input  dar_pkg::t_req              i_req,
    input  logic                       i_cfg_valid,
    input  logic [dar_pkg::CFG_W-1:0]  i_cfg_data,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output dar_pkg::t_rsp              o_out
);
    import dar_pkg::*;

    localparam int FW = $clog2(TABLE_DEPTH + 1);
    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    t_entry          r_mem [TABLE_DEPTH];
    t_entry          r_rd;
    t_entry          w_wr_data;
    logic [AW-1:0]   w_wr_addr;

    t_req            r_req;
    logic [CFG_W-1:0] r_enabled;
    logic [FW-1:0]   r_fill;
    logic [FW-1:0]   r_idx;
    logic            r_rd_vld;
    logic [AW-1:0]   r_rd_idx;
    logic            r_hit;
    logic            r_own_eq;
    logic [AW-1:0]   r_hit_idx;
    logic            r_out_vld;
    t_rsp            r_out;

    logic            w_match;
    logic            w_iface_ok;

    assign w_iface_ok = (32'(r_req.iface) < NUM_IFACES) && r_enabled[r_req.iface];

    always_comb begin
        o_sts          = '0;
        o_sts.drop     = (r_req.reg_hi[ADDR_W-1 -: 8] == 8'hFF)
                      || ((r_req.src_hi == '0) && (r_req.src_lo == '0))
                      || (r_req.src_hi[ADDR_W-1 -: 8] == 8'hFF)
                      || !w_iface_ok;
        o_sts.more     = (r_idx < r_fill);
        o_sts.rd_pend  = r_rd_vld;
        o_sts.hit      = r_hit;
        o_sts.own_eq   = r_own_eq;
        o_sts.full     = (r_fill == FW'(TABLE_DEPTH));
        o_sts.out_busy = r_out_vld && !i_out_ready;
    end

    assign w_match = r_rd_vld && !r_hit
                  && (r_rd.iface == r_req.iface)
                  && (r_rd.addr_hi == r_req.reg_hi)
                  && (r_rd.addr_lo == r_req.reg_lo);

    // insert and refresh both write the request's own fields
    always_comb begin
        w_wr_data.iface    = r_req.iface;
        w_wr_data.addr_hi  = r_req.reg_hi;
        w_wr_data.addr_lo  = r_req.reg_lo;
        w_wr_data.owner    = r_req.eui;
        w_wr_data.lifetime = r_req.life;
        w_wr_addr = i_cmd.wr_hit ? r_hit_idx : r_fill[AW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        if (i_cmd.step) begin
            r_rd <= r_mem[r_idx[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_req <= i_req;
        end
        if (i_cmd.step) begin
            r_rd_idx <= r_idx[AW-1:0];
        end
        if (w_match) begin
            r_hit_idx <= r_rd_idx;
            r_own_eq  <= (r_rd.owner == r_req.eui);
        end
        if (i_cmd.commit) begin
            r_out.iface  <= r_req.iface;
            r_out.status <= i_cmd.status;
            r_out.life   <= r_req.life;
            r_out.eui    <= r_req.eui;
            r_out.reg_hi <= r_req.reg_hi;
            r_out.reg_lo <= r_req.reg_lo;
            r_out.dst_hi <= r_req.src_hi;
            r_out.dst_lo <= r_req.src_lo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled <= '0;
            r_fill    <= '0;
            r_idx     <= '0;
            r_rd_vld  <= 1'b0;
            r_hit     <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_enabled <= i_cfg_data;
            end
            if (i_cmd.inc_fill) begin
                r_fill <= r_fill + 1'b1;
            end
            r_rd_vld <= i_cmd.step;
            if (i_cmd.load_req) begin
                r_idx <= '0;
                r_hit <= 1'b0;
            end else begin
                if (i_cmd.step) begin
                    r_idx <= r_idx + 1'b1;
                end
                if (w_match) begin
                    r_hit <= 1'b1;
                end
            end
            if (i_cmd.commit) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(TABLE_DEPTH))
        else $error("fill count beyond table depth");

    a_fill_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && (r_fill != $past(r_fill)) |-> r_fill == $past(r_fill) + 1'b1)
        else $error("fill count moved by other than one");

    a_read_filled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |-> r_idx < r_fill)
        else $error("read of an entry that was never written");

    a_insert_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.inc_fill |-> !o_sts.full && !r_hit)
        else $error("insert into a full table or over a hit");

endmodule
